/* sv/one_at_a_time_bucket_hash_unit_defines.svh */
// Assertion helpers for the hash unit RTL.
`ifndef ONE_AT_A_TIME_BUCKET_HASH_UNIT_DEFINES_SVH
`define ONE_AT_A_TIME_BUCKET_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define OAAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oaat: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define OAAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oaat: next-cycle check failed");

`endif

/* sv/oaat_pkg.sv */
`default_nettype none

package oaat_pkg;

    localparam int HASH_WIDTH_DEF = 64;
    localparam int BYTE_W         = 8;
    localparam int BUCKET_W       = 16;

    // mix and finalize shift amounts
    localparam int MIX_SHL  = 10;
    localparam int MIX_SHR  = 6;
    localparam int FIN_SHL1 = 3;
    localparam int FIN_SHR  = 11;
    localparam int FIN_SHL2 = 15;

    localparam logic [BUCKET_W-1:0] BUCKETS_RESET = 16'd1;

endpackage

`default_nettype wire

/* sv/one_at_a_time_bucket_hash_unit.sv */
`default_nettype none
// Channel   Handshake                 Payload
// input     i_valid / o_stall         i_data_byte     (8 bits)
// output    o_valid / i_stall         o_bucket_index  (16 bits)
// config    i_cfg_we                  i_cfg_data      (16 bits, bucket count)
//
// A non-zero byte is added on accept, then put through the two mix steps, all on
// the one shared add/xor unit over the running hash.
// A zero byte runs three finalize steps on the same unit, then a restoring modulo
// that retires one hash bit per cycle.
// Reset is synchronous, active low; hash clears to 0 and the bucket count to 1.
// o_stall is high whenever the sequencer is busy; a result waiting on i_stall
// holds the block only when the next result is ready to leave.

`include "one_at_a_time_bucket_hash_unit_defines.svh"

module one_at_a_time_bucket_hash_unit #(
    parameter int HASH_WIDTH = oaat_pkg::HASH_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [oaat_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                               o_stall,
    output logic                               o_valid,
    output logic [oaat_pkg::BUCKET_W-1:0]      o_bucket_index,
    input  wire logic                          i_stall,
    input  wire logic                          i_cfg_we,
    input  wire logic [oaat_pkg::BUCKET_W-1:0] i_cfg_data
);
    import oaat_pkg::*;

    localparam int CNT_W = $clog2(HASH_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MIX1, S_MIX2, S_FIN1, S_FIN2, S_FIN3, S_MOD, S_DONE
    } t_state;

    t_state                r_state;
    logic [HASH_WIDTH-1:0] r_hash;
    logic [BUCKET_W-1:0]   r_buckets;
    logic [BUCKET_W-1:0]   r_rem;
    logic [BUCKET_W-1:0]   n_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_out_valid;
    logic [BUCKET_W-1:0]   r_out_idx;

    logic [HASH_WIDTH-1:0] opnd;
    logic                  use_xor;
    logic [HASH_WIDTH-1:0] alu;
    logic [BUCKET_W:0]     mod_shift;
    logic [BUCKET_W+1:0]   mod_diff;
    logic                  slot_free;

    // shared add/xor unit: operand picked by the sequencer step
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                opnd    = {{(HASH_WIDTH-BYTE_W){i_data_byte[BYTE_W-1]}}, i_data_byte};
                use_xor = 1'b0;
            end
            S_MIX1: begin
                opnd    = r_hash << MIX_SHL;
                use_xor = 1'b0;
            end
            S_MIX2: begin
                opnd    = r_hash >> MIX_SHR;
                use_xor = 1'b1;
            end
            S_FIN1: begin
                opnd    = r_hash << FIN_SHL1;
                use_xor = 1'b0;
            end
            S_FIN2: begin
                opnd    = r_hash >> FIN_SHR;
                use_xor = 1'b1;
            end
            S_FIN3: begin
                opnd    = r_hash << FIN_SHL2;
                use_xor = 1'b0;
            end
            default: begin
                opnd    = '0;
                use_xor = 1'b0;
            end
        endcase
        alu = use_xor ? (r_hash ^ opnd) : (r_hash + opnd);
    end

    // one restoring step: bring in the next hash bit, subtract if it fits
    always_comb begin
        mod_shift = {r_rem, r_hash[HASH_WIDTH-1]};
        mod_diff  = {1'b0, mod_shift} - {2'b00, r_buckets};
        n_rem     = mod_diff[BUCKET_W+1] ? mod_shift[BUCKET_W-1:0]
                                         : mod_diff[BUCKET_W-1:0];
    end

    assign slot_free      = !r_out_valid || !i_stall;
    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_buckets   <= BUCKETS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_buckets <= i_cfg_data;
            end
            // a finished result reloads the slot in S_DONE instead
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data_byte != '0) begin
                            r_hash  <= alu;
                            r_state <= S_MIX1;
                        end else begin
                            r_state <= S_FIN1;
                        end
                    end
                end
                S_MIX1: begin
                    r_hash  <= alu;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_hash  <= alu;
                    r_state <= S_IDLE;
                end
                S_FIN1: begin
                    r_hash  <= alu;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_hash  <= alu;
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    r_hash  <= alu;
                    r_rem   <= '0;
                    r_cnt   <= CNT_LAST;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_rem  <= n_rem;
                    r_hash <= r_hash << 1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DONE: begin
                    // hold until the output register can take the word
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= (r_buckets == '0) ? '0 : r_rem;
                        r_hash      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `OAAT_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n,
        o_valid && r_buckets != '0, o_bucket_index < r_buckets)
    `OAAT_ASSERT_NOW(a_idx_zero_count, i_clk, i_rst_n,
        o_valid && r_buckets == '0, o_bucket_index == '0)
    `OAAT_ASSERT_NEXT(a_term_to_fin, i_clk, i_rst_n,
        i_valid && !o_stall && i_data_byte == '0, r_state == S_FIN1)
    `OAAT_ASSERT_NEXT(a_byte_to_mix, i_clk, i_rst_n,
        i_valid && !o_stall && i_data_byte != '0, r_state == S_MIX1)
    `OAAT_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n,
        r_state == S_DONE && slot_free, r_hash == '0 && r_state == S_IDLE && o_valid)

endmodule

`default_nettype wire

/* bench/bucket_hash_checker.sv */
`default_nettype none

module bucket_hash_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_word_valid,
    input  wire logic                          i_word_stall,
    input  wire logic [oaat_pkg::BYTE_W-1:0]   i_word_byte,
    input  wire logic                          i_index_valid,
    input  wire logic                          i_index_stall,
    input  wire logic [oaat_pkg::BUCKET_W-1:0] i_index_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [oaat_pkg::BUCKET_W-1:0] i_cfg_data,
    output int                                 o_fail_cnt,
    output int                                 o_pending_cnt,
    output int                                 o_index_cnt
);

    import oaat_pkg::*;

    localparam int HW = HASH_WIDTH_DEF;

    logic [HW-1:0]       string_hash;
    logic [BUCKET_W-1:0] bucket_total;
    logic [BUCKET_W-1:0] expected_index_q [$];
    int                  fails;
    int                  indexes;

    initial begin
        o_fail_cnt    = 0;
        o_pending_cnt = 0;
        o_index_cnt   = 0;
        fails         = 0;
        indexes       = 0;
        string_hash   = '0;
        bucket_total  = BUCKETS_RESET;
    end

    // add the sign-extended char, then mix
    function automatic logic [HW-1:0] fold_byte(input logic [HW-1:0] h,
                                                input logic [BYTE_W-1:0] b);
        logic [HW-1:0] acc;
        acc = h + {{(HW-BYTE_W){b[BYTE_W-1]}}, b};
        acc = acc + (acc << MIX_SHL);
        acc = acc ^ (acc >> MIX_SHR);
        return acc;
    endfunction

    function automatic logic [HW-1:0] finalize_hash(input logic [HW-1:0] h);
        logic [HW-1:0] acc;
        acc = h + (h << FIN_SHL1);
        acc = acc ^ (acc >> FIN_SHR);
        acc = acc + (acc << FIN_SHL2);
        return acc;
    endfunction

    always @(posedge i_clk) begin
        logic [HW-1:0]       fin;
        logic [BUCKET_W-1:0] want;
        if (!i_rst_n) begin
            string_hash  = '0;
            bucket_total = BUCKETS_RESET;
            expected_index_q.delete();
        end else begin
            if (i_cfg_we)
                bucket_total = i_cfg_data;
            if (i_index_valid && !i_index_stall) begin
                indexes++;
                if (expected_index_q.size() == 0) begin
                    fails++;
                    $display("%0t: bucket_index expected none, got %0d", $time, i_index_word);
                end else begin
                    want = expected_index_q.pop_front();
                    if (want !== i_index_word) begin
                        fails++;
                        $display("%0t: bucket_index expected %0d, got %0d",
                                 $time, want, i_index_word);
                    end
                end
            end
            if (i_word_valid && !i_word_stall) begin
                if (i_word_byte != '0) begin
                    string_hash = fold_byte(string_hash, i_word_byte);
                end else begin
                    fin = finalize_hash(string_hash);
                    // zero bucket count: no modulo, index reads 0
                    want = (bucket_total == '0) ? '0 : BUCKET_W'(fin % bucket_total);
                    expected_index_q.push_back(want);
                    string_hash = '0;
                end
            end
        end
        o_fail_cnt    <= fails;
        o_pending_cnt <= expected_index_q.size();
        o_index_cnt   <= indexes;
    end

endmodule

`default_nettype wire

/* bench/one_at_a_time_bucket_hash_unit_tb.sv */
`default_nettype none

module one_at_a_time_bucket_hash_unit_tb;

    import oaat_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 64;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [BYTE_W-1:0]   i_data_byte    = '0;
    logic                i_stall        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [BUCKET_W-1:0] i_cfg_data     = '0;
    logic                o_stall;
    logic                o_valid;
    logic [BUCKET_W-1:0] o_bucket_index;

    logic quiet     = 1'b0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    int fail_cnt;
    int pending_cnt;
    int index_cnt;
    int bytes_sent    = 0;
    int settings_used = 0;

    always #4 i_clk = ~i_clk;

    one_at_a_time_bucket_hash_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_bucket_index (o_bucket_index),
        .i_stall        (i_stall),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    bucket_hash_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word_valid  (i_valid),
        .i_word_stall  (o_stall),
        .i_word_byte   (i_data_byte),
        .i_index_valid (o_valid),
        .i_index_stall (i_stall),
        .i_index_word  (o_bucket_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt),
        .o_index_cnt   (index_cnt)
    );

    // offer one word and hold it until it is taken
    task automatic send_word(input logic [BYTE_W-1:0] b);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid     <= 1'b0;
            i_data_byte <= BYTE_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] string_char();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h01;
            default: return BYTE_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_string(input int len);
        for (int k = 0; k < len; k++)
            send_word(string_char());
        send_word('0);
    endtask

    // drain, let the block settle, then write the bucket count
    task automatic set_buckets(input logic [BUCKET_W-1:0] v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [BUCKET_W-1:0] phase_buckets(input int phase);
        case (phase)
            0:       return 16'd2;
            1:       return 16'd65535;
            2:       return 16'd256;
            3:       return BUCKET_W'($urandom_range(3, 40));
            4:       return 16'd0;
            5:       return 16'd1;
            6:       return BUCKET_W'($urandom_range(1, 65535));
            default: return 16'd4099;
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int sent;
        int len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty string under the reset bucket count
        send_word('0);

        set_buckets(16'd65535);
        send_word(8'h01);
        send_word('0);
        send_word(8'hFF);
        send_word('0);
        send_word(8'h7F);
        send_word(8'h80);
        send_word(8'h55);
        send_word(8'hAA);
        send_word('0);
        send_word('0);

        set_buckets(16'd0);
        send_word(8'hAA);
        send_word(8'h55);
        send_word('0);
        send_word('0);

        set_buckets(16'd1);
        send_word(8'hC3);
        send_word('0);

        for (int phase = 0; phase < PHASES; phase++) begin
            set_buckets(phase_buckets(phase));
            if (phase == 1)
                hold_req <= 1'b1;
            if (phase == PHASES - 1)
                quiet <= 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(20, 40);
                    1:       len = 0;
                    default: len = $urandom_range(1, 10);
                endcase
                send_string(len);
                sent += len + 1;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d bytes into %0d bucket indexes over %0d bucket-count settings,",
                 bytes_sent, index_cnt, settings_used);
        $display("with random stalls on both sides and one long output hold-off.");
        if (pending_cnt != 0)
            $display("%0t: %0d bucket indexes never arrived", $time, pending_cnt);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
